/* design/cpsc_pkg.sv */
`default_nettype none

package cpsc_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int FRAC_BITS    = 16;
    localparam int DCNT_W       = $clog2(FRAC_BITS + 1);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CLIP = 1'b1;

    // Q2.16 parameter constants
    localparam logic signed [18:0] T_ZERO = 19'sd0;
    localparam logic signed [18:0] T_ONE  = 19'sd65536;
    localparam logic [17:0]        T_SAT  = 18'd131072;

    typedef logic signed [23:0] coord_t;
    typedef logic signed [24:0] diff_t;
    typedef logic signed [49:0] prod_t;
    typedef logic signed [43:0] tprod_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } pt_t;

    typedef struct packed {
        logic   operation;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
        logic   last_vertex;
    } in_t;

    typedef struct packed {
        logic   hit;
        coord_t clip_start_x;
        coord_t clip_start_y;
        coord_t clip_end_x;
        coord_t clip_end_y;
    } out_t;

    // base + round(p / 2^16), half up; the result stays between the endpoints
    function automatic coord_t scale_add(coord_t base, tprod_t p);
        tprod_t w;
        w = p + 44'sd32768;
        return base + coord_t'(w[39:16]);
    endfunction

endpackage

`default_nettype wire

/* design/cpsc_cell.sv */
`default_nettype none

module cpsc_cell (
    input  logic           clk,
    input  logic           load,
    input  cpsc_pkg::pt_t  load_pt,
    input  logic           shift,
    input  cpsc_pkg::pt_t  shift_pt,
    output cpsc_pkg::pt_t  pt
);

    cpsc_pkg::pt_t pt_reg;

    // load a new corner, or take the neighbor's corner when the ring rotates
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pt_reg <= load_pt;
        end
        else if (shift)
        begin
            pt_reg <= shift_pt;
        end
    end

    assign pt = pt_reg;

endmodule

`default_nettype wire

/* design/cpsc_div.sv */
`default_nettype none

module cpsc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [48:0] num,
    input  logic [48:0] den,
    output logic        done,
    output logic [17:0] quo
);

    logic                          busy_reg, busy_next;
    logic [cpsc_pkg::DCNT_W-1:0]   cnt_reg, cnt_next;
    logic [49:0]                   rem_reg, rem_next;
    logic [17:0]                   quo_reg, quo_next;
    logic [49:0]                   shifted;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        shifted   = {rem_reg[48:0], 1'b0};
        if (start)
        begin
            busy_next = 1'b1;
            if ({1'b0, num} >= {den, 1'b0})
            begin
                // saturate at 2.0
                quo_next = cpsc_pkg::T_SAT;
                rem_next = '0;
                cnt_next = '0;
            end
            else if (num >= den)
            begin
                quo_next = 18'd1;
                rem_next = {1'b0, num - den};
                cnt_next = cpsc_pkg::DCNT_W'(cpsc_pkg::FRAC_BITS);
            end
            else
            begin
                quo_next = 18'd0;
                rem_next = {1'b0, num};
                cnt_next = cpsc_pkg::DCNT_W'(cpsc_pkg::FRAC_BITS);
            end
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                // one restoring step per cycle
                cnt_next = cnt_reg - 1'b1;
                if (shifted >= {1'b0, den})
                begin
                    rem_next = shifted - {1'b0, den};
                    quo_next = {quo_reg[16:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted;
                    quo_next = {quo_reg[16:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done = busy_reg && (cnt_reg == '0);
    assign quo  = quo_reg;

endmodule

`default_nettype wire

/* design/convex_polygon_segment_clip.sv */
`default_nettype none

// Convex polygon segment clipper (Cyrus-Beck).
// Input channel in_valid/in_ready carries one request: operation 0 loads a
// polygon corner (last_vertex closes the polygon), operation 1 clips the
// segment start..end against the closed polygon. Only clip requests produce
// a response on out_valid/out_ready: hit plus the clipped endpoints, all
// zero when hit is 0. cfg_we/cfg_wdata write the tolerance at any edge.
// Corners live in a ring of cells; a clip rotates the ring one corner per
// edge so that the first two cells always hold the current edge.
// A corner load runs the shoelace term through one multiply and one add
// stage, a closing term through another pair. A clip works each edge in
// turn: a parallel edge passes on, any other edge waits for the bit-serial
// divider (one quotient bit per cycle; it stops at once when the parameter
// saturates), edges left after a miss only rotate, and a hit is scaled last.
// One request is worked at a time; in_ready is high only while idle.
// A finished response waits in the output register while the block takes
// the next request; a clip finishing while the receiver stalls holds until
// the output register frees. Reset empties the polygon (a clip then misses)
// and sets the tolerance to 1.

module convex_polygon_segment_clip (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cpsc_pkg::in_t     in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output cpsc_pkg::out_t    out_data,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata
);

    localparam int MAXV  = cpsc_pkg::MAX_VERTICES;
    localparam int CNT_W = cpsc_pkg::CNT_W;
    localparam int IDX_W = cpsc_pkg::IDX_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_AMUL = 4'd1;
    localparam logic [3:0] S_AADD = 4'd2;
    localparam logic [3:0] S_CSET = 4'd3;
    localparam logic [3:0] S_E0   = 4'd4;
    localparam logic [3:0] S_E1   = 4'd5;
    localparam logic [3:0] S_E2   = 4'd6;
    localparam logic [3:0] S_E3   = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;
    localparam logic [3:0] S_MUL  = 4'd10;
    localparam logic [3:0] S_SUM  = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    // control state
    logic [3:0]       state_reg, state_next;
    logic [15:0]      tol_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             closed_reg, closed_next;
    logic             cw_reg, cw_next;
    logic             close_pend_reg, close_pend_next;
    logic             closing_reg, closing_next;
    logic [CNT_W-1:0] edge_reg, edge_next;
    logic             miss_reg, miss_next;
    logic             out_valid_reg, out_valid_next;

    // datapath
    logic signed [53:0]     area_reg, area_next;
    cpsc_pkg::pt_t          prev_reg, prev_next, first_reg, first_next;
    cpsc_pkg::pt_t          opa_reg, opa_next, opb_reg, opb_next;
    logic signed [47:0]     m1_reg, m1_next, m2_reg, m2_next;
    cpsc_pkg::pt_t          sa_reg, sa_next;
    cpsc_pkg::diff_t        dx_reg, dx_next, dy_reg, dy_next;
    cpsc_pkg::diff_t        nx_reg, nx_next, ny_reg, ny_next;
    cpsc_pkg::diff_t        ox_reg, ox_next, oy_reg, oy_next;
    cpsc_pkg::prod_t        pd1_reg, pd1_next, pd2_reg, pd2_next;
    cpsc_pkg::prod_t        pd3_reg, pd3_next, pd4_reg, pd4_next;
    cpsc_pkg::prod_t        dist_reg, dist_next, rate_reg, rate_next;
    logic                   neg_reg, neg_next, rpos_reg, rpos_next;
    logic signed [18:0]     tin_reg, tin_next, tout_reg, tout_next;
    cpsc_pkg::tprod_t       q1_reg, q1_next, q2_reg, q2_next;
    cpsc_pkg::tprod_t       q3_reg, q3_next, q4_reg, q4_next;
    cpsc_pkg::out_t         res_reg, res_next, out_reg, out_next;

    // helpers
    logic                   accept;
    logic [CNT_W-1:0]       eff_cnt, edge_inc;
    logic                   room;
    cpsc_pkg::pt_t          s_pt;
    logic                   cell_load, rotate;
    cpsc_pkg::pt_t          cell_pt [MAXV];
    logic signed [53:0]     area_sum;
    cpsc_pkg::diff_t        ex, ey;
    cpsc_pkg::prod_t        dist_mag, rate_mag, neg_tsq;
    logic [48:0]            tsq;
    logic                   div_start, div_done;
    logic [17:0]            div_quo;
    logic signed [18:0]     t_val, tin_upd, tout_upd, tin_c, tout_c;
    logic signed [19:0]     span;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign eff_cnt   = closed_reg ? '0 : count_reg;
    assign room      = (eff_cnt < CNT_W'(MAXV));
    assign edge_inc  = edge_reg + CNT_W'(1);
    assign s_pt.x    = in_data.start_x;
    assign s_pt.y    = in_data.start_y;
    assign area_sum  = area_reg + 54'(m1_reg) - 54'(m2_reg);
    assign ex        = cpsc_pkg::diff_t'(cell_pt[1].x) - cpsc_pkg::diff_t'(cell_pt[0].x);
    assign ey        = cpsc_pkg::diff_t'(cell_pt[1].y) - cpsc_pkg::diff_t'(cell_pt[0].y);
    assign dist_mag  = dist_reg[49] ? -dist_reg : dist_reg;
    assign rate_mag  = rate_reg[49] ? -rate_reg : rate_reg;
    assign tsq       = {25'd0, tol_reg, 8'd0};
    assign neg_tsq   = -$signed({26'd0, tol_reg, 8'd0});
    assign t_val     = neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    assign tin_upd   = (rpos_reg && (t_val > tin_reg)) ? t_val : tin_reg;
    assign tout_upd  = (!rpos_reg && (t_val < tout_reg)) ? t_val : tout_reg;
    assign tin_c     = (tin_reg < cpsc_pkg::T_ZERO) ? cpsc_pkg::T_ZERO : tin_reg;
    assign tout_c    = (tout_reg > cpsc_pkg::T_ONE) ? cpsc_pkg::T_ONE : tout_reg;
    assign span      = 20'(tout_c) - 20'(tin_c);

    // ring of corner cells; the cell at the ring's end takes from cell 0
    for (genvar k = 0; k < MAXV; k++)
    begin : g_cell
        cpsc_pkg::pt_t nb;
        if (k == MAXV - 1)
        begin : g_last
            assign nb = cell_pt[0];
        end
        else
        begin : g_mid
            localparam logic [CNT_W-1:0] KP1 = CNT_W'(k + 1);
            assign nb = (count_reg == KP1) ? cell_pt[0] : cell_pt[k + 1];
        end
        cpsc_cell u_cell (
            .clk      (clk),
            .load     (cell_load && (eff_cnt[IDX_W-1:0] == IDX_W'(k))),
            .load_pt  (s_pt),
            .shift    (rotate),
            .shift_pt (nb),
            .pt       (cell_pt[k])
        );
    end

    cpsc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (dist_mag[48:0]),
        .den   (rate_mag[48:0]),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        closed_next     = closed_reg;
        cw_next         = cw_reg;
        close_pend_next = close_pend_reg;
        closing_next    = closing_reg;
        edge_next       = edge_reg;
        miss_next       = miss_reg;
        out_valid_next  = out_valid_reg;
        area_next       = area_reg;
        prev_next       = prev_reg;
        first_next      = first_reg;
        opa_next        = opa_reg;
        opb_next        = opb_reg;
        m1_next         = m1_reg;
        m2_next         = m2_reg;
        sa_next         = sa_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        nx_next         = nx_reg;
        ny_next         = ny_reg;
        ox_next         = ox_reg;
        oy_next         = oy_reg;
        pd1_next        = pd1_reg;
        pd2_next        = pd2_reg;
        pd3_next        = pd3_reg;
        pd4_next        = pd4_reg;
        dist_next       = dist_reg;
        rate_next       = rate_reg;
        neg_next        = neg_reg;
        rpos_next       = rpos_reg;
        tin_next        = tin_reg;
        tout_next       = tout_reg;
        q1_next         = q1_reg;
        q2_next         = q2_reg;
        q3_next         = q3_reg;
        q4_next         = q4_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        cell_load       = 1'b0;
        rotate          = 1'b0;
        div_start       = 1'b0;

        // drop the response once the receiver takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.operation == cpsc_pkg::OP_LOAD)
                    begin
                        // a load after a closed polygon starts a new one
                        if (closed_reg)
                        begin
                            area_next   = '0;
                            cw_next     = 1'b0;
                            closed_next = 1'b0;
                            count_next  = '0;
                        end
                        close_pend_next = in_data.last_vertex;
                        if (room)
                        begin
                            cell_load  = 1'b1;
                            count_next = eff_cnt + CNT_W'(1);
                            prev_next  = s_pt;
                            opa_next   = prev_reg;
                            opb_next   = s_pt;
                            if (eff_cnt == '0)
                            begin
                                first_next = s_pt;
                            end
                        end
                        if (room && (eff_cnt != '0))
                        begin
                            state_next = S_AMUL;
                        end
                        else if (in_data.last_vertex)
                        begin
                            state_next = S_CSET;
                        end
                    end
                    else
                    begin
                        sa_next   = s_pt;
                        dx_next   = cpsc_pkg::diff_t'(in_data.end_x)
                                  - cpsc_pkg::diff_t'(in_data.start_x);
                        dy_next   = cpsc_pkg::diff_t'(in_data.end_y)
                                  - cpsc_pkg::diff_t'(in_data.start_y);
                        edge_next = '0;
                        miss_next = 1'b0;
                        tin_next  = cpsc_pkg::T_ZERO;
                        tout_next = cpsc_pkg::T_ONE;
                        // open or small polygon: answer a miss at once
                        if (!closed_reg || (count_reg < CNT_W'(3)))
                        begin
                            res_next   = '0;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            state_next = S_E0;
                        end
                    end
                end
            end
            S_AMUL:
            begin
                m1_next    = opa_reg.x * opb_reg.y;
                m2_next    = opb_reg.x * opa_reg.y;
                state_next = S_AADD;
            end
            S_AADD:
            begin
                area_next = area_sum;
                if (closing_reg)
                begin
                    // a zero area counts as counter-clockwise
                    cw_next         = area_sum < 0;
                    closed_next     = 1'b1;
                    closing_next    = 1'b0;
                    close_pend_next = 1'b0;
                    state_next      = S_IDLE;
                end
                else if (close_pend_reg)
                begin
                    state_next = S_CSET;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_CSET:
            begin
                // closing edge: last stored corner back to the first
                opa_next     = prev_reg;
                opb_next     = first_reg;
                closing_next = 1'b1;
                state_next   = S_AMUL;
            end
            S_E0:
            begin
                if (miss_reg)
                begin
                    // keep rotating so the ring ends where it started
                    rotate     = 1'b1;
                    edge_next  = edge_inc;
                    state_next = (edge_inc == count_reg) ? S_FIN : S_E0;
                end
                else
                begin
                    nx_next    = cw_reg ? ey : -ey;
                    ny_next    = cw_reg ? -ex : ex;
                    ox_next    = cpsc_pkg::diff_t'(sa_reg.x) - cpsc_pkg::diff_t'(cell_pt[0].x);
                    oy_next    = cpsc_pkg::diff_t'(sa_reg.y) - cpsc_pkg::diff_t'(cell_pt[0].y);
                    state_next = S_E1;
                end
            end
            S_E1:
            begin
                pd1_next   = nx_reg * ox_reg;
                pd2_next   = ny_reg * oy_reg;
                pd3_next   = nx_reg * dx_reg;
                pd4_next   = ny_reg * dy_reg;
                state_next = S_E2;
            end
            S_E2:
            begin
                dist_next  = pd1_reg + pd2_reg;
                rate_next  = pd3_reg + pd4_reg;
                state_next = S_E3;
            end
            S_E3:
            begin
                if ((rate_reg == '0) || (rate_mag[48:0] < tsq))
                begin
                    // parallel edge: reject if outside, else pass on
                    if (dist_reg < neg_tsq)
                    begin
                        miss_next = 1'b1;
                    end
                    rotate     = 1'b1;
                    edge_next  = edge_inc;
                    state_next = (edge_inc == count_reg) ? S_FIN : S_E0;
                end
                else
                begin
                    div_start  = 1'b1;
                    neg_next   = ((dist_reg > 0) == (rate_reg > 0)) && (dist_reg != '0);
                    rpos_next  = rate_reg > 0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    tin_next  = tin_upd;
                    tout_next = tout_upd;
                    if (20'(tin_upd) > (20'(tout_upd) + $signed({4'd0, tol_reg})))
                    begin
                        miss_next = 1'b1;
                    end
                    rotate     = 1'b1;
                    edge_next  = edge_inc;
                    state_next = (edge_inc == count_reg) ? S_FIN : S_E0;
                end
            end
            S_FIN:
            begin
                if (miss_reg || (span <= $signed({4'd0, tol_reg})))
                begin
                    res_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    tin_next   = tin_c;
                    tout_next  = tout_c;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                q1_next    = tin_reg * dx_reg;
                q2_next    = tin_reg * dy_reg;
                q3_next    = tout_reg * dx_reg;
                q4_next    = tout_reg * dy_reg;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                res_next.hit          = 1'b1;
                res_next.clip_start_x = cpsc_pkg::scale_add(sa_reg.x, q1_reg);
                res_next.clip_start_y = cpsc_pkg::scale_add(sa_reg.y, q2_reg);
                res_next.clip_end_x   = cpsc_pkg::scale_add(sa_reg.x, q3_reg);
                res_next.clip_end_y   = cpsc_pkg::scale_add(sa_reg.y, q4_reg);
                state_next            = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register frees
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tol_reg        <= 16'd1;
            count_reg      <= '0;
            closed_reg     <= 1'b1;
            cw_reg         <= 1'b0;
            close_pend_reg <= 1'b0;
            closing_reg    <= 1'b0;
            edge_reg       <= '0;
            miss_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            area_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            closed_reg     <= closed_next;
            cw_reg         <= cw_next;
            close_pend_reg <= close_pend_next;
            closing_reg    <= closing_next;
            edge_reg       <= edge_next;
            miss_reg       <= miss_next;
            out_valid_reg  <= out_valid_next;
            area_reg       <= area_next;
            if (cfg_we)
            begin
                tol_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg  <= prev_next;
        first_reg <= first_next;
        opa_reg   <= opa_next;
        opb_reg   <= opb_next;
        m1_reg    <= m1_next;
        m2_reg    <= m2_next;
        sa_reg    <= sa_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        nx_reg    <= nx_next;
        ny_reg    <= ny_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        pd1_reg   <= pd1_next;
        pd2_reg   <= pd2_next;
        pd3_reg   <= pd3_next;
        pd4_reg   <= pd4_next;
        dist_reg  <= dist_next;
        rate_reg  <= rate_next;
        neg_reg   <= neg_next;
        rpos_reg  <= rpos_next;
        tin_reg   <= tin_next;
        tout_reg  <= tout_next;
        q1_reg    <= q1_next;
        q2_reg    <= q2_next;
        q3_reg    <= q3_next;
        q4_reg    <= q4_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAXV))
        else $error("corner count beyond ring size");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide step");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.hit) |-> ((out_reg.clip_start_x == '0)
        && (out_reg.clip_start_y == '0) && (out_reg.clip_end_x == '0)
        && (out_reg.clip_end_y == '0)))
        else $error("miss response carries nonzero endpoints");

    a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_E0) || (state_reg == S_DIV)) |-> (edge_reg < count_reg))
        else $error("edge walk past the last corner");
`endif

endmodule

`default_nettype wire
